[hw/rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");

// property checked outside reset
`define ASSERT_RUN(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

`endif

[hw/rtl/brobs_pkg.sv]
package brobs_pkg;

  localparam int SCAN_SAMPLES  = 360;
  localparam int HISTORY_DEPTH = 256;

  localparam int RANGE_W    = 16;
  localparam int STEER_W    = 16;
  localparam int STEP_W     = 12;
  localparam int SRC_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int CNT_W  = $clog2(SCAN_SAMPLES + 1);
  localparam int KW     = (CNT_W > 9) ? CNT_W : 9;
  localparam int OFF_W  = STEP_W + CNT_W;
  localparam int ANG_W  = OFF_W + 2;
  localparam int PROD_W = 32;
  localparam int WSUM_W = 48;
  localparam int RSUM_W = 25;
  localparam int DIV_W  = WSUM_W + 1;
  localparam int DCNT_W = $clog2(DIV_W);

  localparam int LVL_W = $clog2(HISTORY_DEPTH + 1);
  localparam int IDX_W = $clog2(HISTORY_DEPTH);

  localparam int QDEPTH = 4;
  localparam int QCNT_W = $clog2(QDEPTH + 1);
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam int OBUF_DEPTH = 2;
  localparam int OCNT_W     = $clog2(OBUF_DEPTH + 1);
  localparam int OPTR_W     = $clog2(OBUF_DEPTH);

  localparam logic signed [STEER_W-1:0] START_ANGLE_RESET = -16'sd25736;
  localparam logic [STEP_W-1:0]         ANGLE_STEP_RESET  = 12'd143;
  localparam logic signed [STEER_W-1:0] HALF_PI_Q13       = 16'sd12868;
  localparam logic signed [STEER_W-1:0] STEER_MAX         = 16'sh7FFF;
  localparam logic signed [STEER_W-1:0] STEER_MIN         = 16'sh8000;

  localparam int BUBBLE_SPAN = 360;
  localparam int BUBBLE_FLAT = 29;
  localparam int BUBBLE_EDGE = 89;
  localparam int BUBBLE_DIV  = 329;
  localparam int BUBBLE_MM   = 500;

  localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP  = CFG_IDX_W'(1);

  localparam logic [SRC_W-1:0] SRC_NEW    = 2'd0;
  localparam logic [SRC_W-1:0] SRC_RECALL = 2'd1;
  localparam logic [SRC_W-1:0] SRC_EMPTY  = 2'd2;

  typedef struct packed {
    logic                     obstacle;
    logic signed [WSUM_W-1:0] wsum;
    logic [RSUM_W-1:0]        rsum;
  } scan_rec_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              empty;
  } rq_status_t;

  typedef struct packed {
    logic signed [STEER_W-1:0] steer;
    logic [SRC_W-1:0]          src;
    logic                      ovf;
  } result_t;

  function automatic logic below_bubble(input logic [CNT_W-1:0] k,
                                        input logic [RANGE_W-1:0] range);
    logic [KW-1:0] kk;
    logic [KW-1:0] j;
    logic [24:0]   lhs;
    logic [24:0]   rhs;
    logic          hit;
    kk  = KW'(k);
    hit = 1'b0;
    j   = (kk < KW'(BUBBLE_SPAN / 2)) ? kk : KW'(BUBBLE_SPAN - 1) - kk;
    lhs = 25'(range) * 25'(BUBBLE_DIV);
    rhs = 25'(KW'(BUBBLE_SPAN - 1) - j) * 25'(BUBBLE_MM);
    if (kk < KW'(BUBBLE_SPAN)) begin
      if (j <= KW'(BUBBLE_FLAT)) begin
        hit = range < RANGE_W'(BUBBLE_MM);
      end else if (j <= KW'(BUBBLE_EDGE)) begin
        hit = lhs < rhs;
      end
    end
    return hit;
  endfunction

endpackage

[hw/rtl/brobs_front.sv]
module brobs_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [brobs_pkg::RANGE_W-1:0]  range_mm,
  input  logic                           last_sample,
  input  logic                           cfg_valid,
  input  logic [brobs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [brobs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  brobs_pkg::rq_status_t          q_status,
  output logic                           rec_push,
  output brobs_pkg::scan_rec_t           rec
);
  import brobs_pkg::*;

  localparam logic signed [ANG_W-1:0] ANG_MAX = ANG_W'(32767);
  localparam logic signed [ANG_W-1:0] ANG_MIN = ANG_W'(-32768);

  logic signed [STEER_W-1:0] start_angle;
  logic [STEP_W-1:0]         angle_step;
  logic [CNT_W-1:0]          sample_count;
  logic                      accept;

  logic                s1_valid;
  logic                s1_last;
  logic                s1_ok;
  logic [CNT_W-1:0]    s1_k;
  logic [RANGE_W-1:0]  s1_range;
  logic [OFF_W-1:0]    s1_off;

  logic                      s2_valid;
  logic                      s2_last;
  logic                      s2_hit;
  logic signed [STEER_W-1:0] s2_ang;
  logic [RANGE_W-1:0]        s2_range;

  logic                     s3_valid;
  logic                     s3_last;
  logic                     s3_hit;
  logic signed [PROD_W-1:0] s3_prod;
  logic [RANGE_W-1:0]       s3_range;

  logic signed [WSUM_W-1:0] wsum;
  logic [RSUM_W-1:0]        rsum;
  logic                     obstacle;

  logic signed [ANG_W-1:0]           ang_full;
  logic signed [STEER_W-1:0]         ang_sat;
  logic                              rear;
  logic signed [RANGE_W+STEER_W:0]   prod_full;
  logic [QCNT_W+1:0]                 pending;
  logic                              hit_v;
  logic signed [WSUM_W-1:0]          wsum_next;
  logic [RSUM_W-1:0]                 rsum_next;
  logic                              obstacle_next;

  assign pending = (QCNT_W + 2)'(q_status.count) + (QCNT_W + 2)'(s1_last)
                 + (QCNT_W + 2)'(s2_last) + (QCNT_W + 2)'(s3_last);
  assign full    = pending >= (QCNT_W + 2)'(QDEPTH);
  assign accept  = push & ~full;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_angle <= START_ANGLE_RESET;
      angle_step  <= ANGLE_STEP_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_START_ANGLE: start_angle <= cfg_data;
        REG_ANGLE_STEP:  angle_step  <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
    end else if (accept) begin
      if (last_sample) begin
        sample_count <= '0;
      end else if (sample_count < CNT_W'(SCAN_SAMPLES)) begin
        sample_count <= sample_count + CNT_W'(1);
      end
    end
  end

  // stage 1: index and angle offset
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_last  <= 1'b0;
    end else begin
      s1_valid <= accept;
      s1_last  <= accept & last_sample;
    end
    s1_ok    <= sample_count < CNT_W'(SCAN_SAMPLES);
    s1_k     <= sample_count;
    s1_range <= range_mm;
    s1_off   <= OFF_W'(angle_step) * OFF_W'(sample_count);
  end

  // stage 2: saturated angle and obstacle test
  assign ang_full = ANG_W'(start_angle) + $signed({2'b00, s1_off});

  always_comb begin
    if (ang_full > ANG_MAX) begin
      ang_sat = STEER_MAX;
    end else if (ang_full < ANG_MIN) begin
      ang_sat = STEER_MIN;
    end else begin
      ang_sat = ang_full[STEER_W-1:0];
    end
  end

  assign rear = (ang_sat >= HALF_PI_Q13) || (ang_sat <= -HALF_PI_Q13);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s2_last  <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
      s2_last  <= s1_last;
    end
    s2_hit   <= s1_ok & rear & below_bubble(s1_k, s1_range);
    s2_ang   <= ang_sat;
    s2_range <= s1_range;
  end

  // stage 3: angle times range
  assign prod_full = s2_ang * $signed({1'b0, s2_range});

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
      s3_last  <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
      s3_last  <= s2_last;
    end
    s3_hit   <= s2_hit;
    s3_prod  <= prod_full[PROD_W-1:0];
    s3_range <= s2_range;
  end

  // stage 4: scan sums
  assign hit_v         = s3_valid & s3_hit;
  assign wsum_next     = hit_v ? wsum + WSUM_W'(s3_prod) : wsum;
  assign rsum_next     = hit_v ? rsum + RSUM_W'(s3_range) : rsum;
  assign obstacle_next = obstacle | hit_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      wsum     <= '0;
      rsum     <= '0;
      obstacle <= 1'b0;
    end else if (s3_valid) begin
      if (s3_last) begin
        wsum     <= '0;
        rsum     <= '0;
        obstacle <= 1'b0;
      end else begin
        wsum     <= wsum_next;
        rsum     <= rsum_next;
        obstacle <= obstacle_next;
      end
    end
  end

  assign rec_push     = s3_valid & s3_last;
  assign rec.obstacle = obstacle_next;
  assign rec.wsum     = wsum_next;
  assign rec.rsum     = rsum_next;

endmodule

[hw/rtl/brobs_rec_queue.sv]
module brobs_rec_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  brobs_pkg::scan_rec_t  din,
  input  logic                  pop,
  output brobs_pkg::scan_rec_t  dout,
  output brobs_pkg::rq_status_t status
);
  import brobs_pkg::*;

  scan_rec_t         entries [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + QPTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= din;
    end
  end

  assign dout         = entries[rptr];
  assign status.count = count;
  assign status.empty = count == '0;

endmodule

[hw/rtl/brobs_back.sv]
module brobs_back (
  input  logic                               clk,
  input  logic                               rst,
  input  brobs_pkg::rq_status_t              q_status,
  input  brobs_pkg::scan_rec_t               rec,
  output logic                               rec_pop,
  input  logic                               pop,
  output logic                               empty,
  output logic signed [brobs_pkg::STEER_W-1:0] steer_angle,
  output logic [brobs_pkg::SRC_W-1:0]        source,
  output logic                               history_overflow
);
  import brobs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ROUND,
    ST_READ,
    ST_EMIT
  } state_t;

  state_t                    state;
  logic                      neg;
  logic [RSUM_W-1:0]         den;
  logic [DIV_W-1:0]          dvd;
  logic [DIV_W-1:0]          quo;
  logic [RSUM_W-1:0]         rem;
  logic [DCNT_W-1:0]         bit_cnt;
  logic [LVL_W-1:0]          level;
  result_t                   res;
  logic signed [STEER_W-1:0] rd_data;

  logic [STEER_W-1:0] hist_mem [HISTORY_DEPTH];

  result_t           obuf [OBUF_DEPTH];
  logic [OCNT_W-1:0] ocount;
  logic [OPTR_W-1:0] owptr;
  logic [OPTR_W-1:0] orptr;
  logic              obuf_push;
  logic              obuf_pop;

  logic signed [DIV_W-1:0]   wext;
  logic [DIV_W-1:0]          mag;
  logic [RSUM_W:0]           rem_sh;
  logic                      ge;
  logic [RSUM_W-1:0]         rem_next;
  logic [STEER_W:0]          qmag;
  logic signed [STEER_W:0]   sval;
  logic signed [STEER_W-1:0] rebound;
  logic signed [STEER_W-1:0] recall;
  logic [LVL_W-1:0]          level_m1;
  logic                      wr_en;
  logic                      rd_en;
  logic                      has_room;

  assign rec_pop  = (state == ST_IDLE) && !q_status.empty;
  assign wext     = DIV_W'(rec.wsum);
  assign mag      = wext[DIV_W-1] ? DIV_W'(-wext) : DIV_W'(wext);
  assign level_m1 = level - LVL_W'(1);
  assign has_room = level < LVL_W'(HISTORY_DEPTH);

  // restoring divider, one quotient bit per cycle
  assign rem_sh   = {rem, dvd[DIV_W-1]};
  assign ge       = rem_sh >= {1'b0, den};
  assign rem_next = ge ? RSUM_W'(rem_sh - {1'b0, den}) : rem_sh[RSUM_W-1:0];

  always_comb begin
    qmag = (quo > DIV_W'(32768)) ? (STEER_W + 1)'(32768) : quo[STEER_W:0];
    if (den == '0) begin
      sval = '0;
    end else if (neg) begin
      sval = -$signed(qmag);
    end else if (qmag > (STEER_W + 1)'(32767)) begin
      sval = (STEER_W + 1)'(32767);
    end else begin
      sval = $signed(qmag);
    end
  end

  assign rebound = sval[STEER_W-1:0];
  assign recall  = (rd_data == STEER_MIN) ? STEER_MAX : -rd_data;
  assign wr_en   = (state == ST_ROUND) && has_room;
  assign rd_en   = rec_pop && !rec.obstacle && (level != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      level <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (rec_pop) begin
            neg     <= rec.wsum[WSUM_W-1];
            den     <= rec.rsum;
            dvd     <= mag + DIV_W'(rec.rsum >> 1);
            quo     <= '0;
            rem     <= '0;
            bit_cnt <= DCNT_W'(DIV_W - 1);
            if (rec.obstacle) begin
              state <= ST_DIV;
            end else if (level == '0) begin
              res   <= '{steer: '0, src: SRC_EMPTY, ovf: 1'b0};
              state <= ST_EMIT;
            end else begin
              state <= ST_READ;
            end
          end
        end
        ST_DIV: begin
          rem     <= rem_next;
          quo     <= {quo[DIV_W-2:0], ge};
          dvd     <= {dvd[DIV_W-2:0], 1'b0};
          bit_cnt <= bit_cnt - DCNT_W'(1);
          if (bit_cnt == '0) begin
            state <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          res <= '{steer: rebound, src: SRC_NEW, ovf: !has_room};
          if (has_room) begin
            level <= level + LVL_W'(1);
          end
          state <= ST_EMIT;
        end
        ST_READ: begin
          res   <= '{steer: recall, src: SRC_RECALL, ovf: 1'b0};
          level <= level_m1;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (obuf_push) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // history stack
  always_ff @(posedge clk) begin
    if (wr_en) begin
      hist_mem[level[IDX_W-1:0]] <= rebound;
    end
    if (rd_en) begin
      rd_data <= hist_mem[level_m1[IDX_W-1:0]];
    end
  end

  // result buffer
  assign obuf_push = (state == ST_EMIT) && (ocount != OCNT_W'(OBUF_DEPTH));
  assign obuf_pop  = pop && (ocount != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      ocount <= '0;
      owptr  <= '0;
      orptr  <= '0;
    end else begin
      if (obuf_push) begin
        owptr <= owptr + OPTR_W'(1);
      end
      if (obuf_pop) begin
        orptr <= orptr + OPTR_W'(1);
      end
      if (obuf_push && !obuf_pop) begin
        ocount <= ocount + OCNT_W'(1);
      end else if (obuf_pop && !obuf_push) begin
        ocount <= ocount - OCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (obuf_push) begin
      obuf[owptr] <= res;
    end
  end

  assign empty            = ocount == '0;
  assign steer_angle      = obuf[orptr].steer;
  assign source           = obuf[orptr].src;
  assign history_overflow = obuf[orptr].ovf;

endmodule

[hw/rtl/bubble_rebound_obstacle_steer_unit.sv]
// Rear-half bubble rebound steering unit.
// Input queue side: one lidar range sample per item (range_mm, last_sample),
// pushed with push while full is low, in scan order. Sample angles follow
// start_angle + n * angle_step, set through the cfg port (index 0, index 1);
// cfg_ready stays high. Writes go between scans with nothing in flight; the user
// keeps to this, as the block does not enforce it. Result queue side: one
// steering item per scan, shown while empty is low, taken with pop. Samples are
// taken one per cycle while full is low; a scan end waits in a four-entry queue,
// and full rises once four scan ends are queued or in flight. A scan's result
// reaches the ports through the four front stages and the scan-end queue, then
// the restoring divider, rounding and the stack write when an obstacle was seen,
// the stack read when history is recalled, nothing more when it is empty, and
// last the result buffer. The back end handles one scan end at a time, taking
// no new one until its result is buffered, so short scans back up into the queue.
// Reset (rst, synchronous) empties the history stack, the queues and the
// scan sums and restores the register defaults; the stack memory itself is
// not cleared. A stalled receiver fills the two-entry result buffer, the
// back end then holds, the scan-end queue fills and full stops the input.
module bubble_rebound_obstacle_steer_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  logic [brobs_pkg::RANGE_W-1:0]        range_mm,
  input  logic                                 last_sample,
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [brobs_pkg::STEER_W-1:0] steer_angle,
  output logic [brobs_pkg::SRC_W-1:0]          source,
  output logic                                 history_overflow,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [brobs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [brobs_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import brobs_pkg::*;

  rq_status_t q_status;
  scan_rec_t  rec_in;
  scan_rec_t  rec_out;
  logic       rec_push;
  logic       rec_pop;

  assign cfg_ready = 1'b1;

  brobs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .range_mm    (range_mm),
    .last_sample (last_sample),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_status    (q_status),
    .rec_push    (rec_push),
    .rec         (rec_in)
  );

  brobs_rec_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (rec_push),
    .din    (rec_in),
    .pop    (rec_pop),
    .dout   (rec_out),
    .status (q_status)
  );

  brobs_back u_back (
    .clk              (clk),
    .rst              (rst),
    .q_status         (q_status),
    .rec              (rec_out),
    .rec_pop          (rec_pop),
    .pop              (pop),
    .empty            (empty),
    .steer_angle      (steer_angle),
    .source           (source),
    .history_overflow (history_overflow)
  );

endmodule

[hw/rtl/brobs_checker.sv]
`include "assert_macros.svh"

module brobs_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 empty,
  input logic                                 pop,
  input logic signed [brobs_pkg::STEER_W-1:0] steer_angle,
  input logic [brobs_pkg::SRC_W-1:0]          source,
  input logic                                 history_overflow
);
  import brobs_pkg::*;

  `ASSERT_RUN(a_empty_zero, clk, rst, (!empty && source == SRC_EMPTY) |-> (steer_angle == 0 && !history_overflow))
  `ASSERT_RUN(a_ovf_new_only, clk, rst, (!empty && source != SRC_NEW) |-> !history_overflow)
  `ASSERT_RUN(a_src_code, clk, rst, !empty |-> (source == SRC_NEW || source == SRC_RECALL || source == SRC_EMPTY))
  `ASSERT_ALWAYS(a_reset_empty, clk, rst |=> empty)
  `ASSERT_RUN(a_hold, clk, rst, (!empty && !pop) |=> (!empty && $stable(steer_angle) && $stable(source)))

endmodule

bind bubble_rebound_obstacle_steer_unit brobs_checker u_checker (.*);

[tb/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import brobs_pkg::*;

  localparam int NEAR  = 0;
  localparam int FAR   = 1;
  localparam int MIXED = 2;

  typedef struct packed {
    logic [RANGE_W-1:0] mm;
    logic               last;
  } lidar_sample_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      push = 1'b0;
  logic                      full;
  logic [RANGE_W-1:0]        range_mm = '0;
  logic                      last_sample = 1'b0;
  logic                      empty;
  logic                      pop = 1'b0;
  logic signed [STEER_W-1:0] steer_angle;
  logic [SRC_W-1:0]          source;
  logic                      history_overflow;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;

  bubble_rebound_obstacle_steer_unit i_dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .range_mm(range_mm),
    .last_sample(last_sample),
    .empty(empty),
    .pop(pop),
    .steer_angle(steer_angle),
    .source(source),
    .history_overflow(history_overflow),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // steering model state
  logic signed [STEER_W-1:0] start_q13 = START_ANGLE_RESET;
  logic [STEP_W-1:0]         step_q13  = ANGLE_STEP_RESET;
  int                        scan_idx = 0;
  longint                    moment_sum = 0;
  int                        mm_sum = 0;
  bit                        saw_obstacle = 1'b0;
  logic signed [STEER_W-1:0] steer_stack[$];

  lidar_sample_t scan_samples[$];
  result_t       rebound_due[$];
  lidar_sample_t next_sample;
  result_t       want;

  bit in_fire = 1'b0;
  bit out_fire = 1'b0;
  int send_gap = 0;
  int send_calm = 0;
  int pop_hold = 0;
  int recv_calm = 0;

  int fail_cnt = 0;
  int n_samples = 0;
  int n_checked = 0;
  int n_rebound = 0;
  int n_recall = 0;
  int n_empty = 0;
  int n_dropped = 0;
  int n_cfg_writes = 0;

  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 31) == 0) calm_left = $urandom_range(16, 64);
    return $urandom_range(0, 13);
  endfunction

  function automatic bit hits_bubble(input int k, input logic [RANGE_W-1:0] mm);
    int j;
    if (k >= BUBBLE_SPAN) return 1'b0;
    j = (k < BUBBLE_SPAN / 2) ? k : BUBBLE_SPAN - 1 - k;
    if (j > BUBBLE_EDGE) return 1'b0;
    if (j > BUBBLE_FLAT) return int'(mm) * BUBBLE_DIV < (BUBBLE_SPAN - 1 - j) * BUBBLE_MM;
    return int'(mm) < BUBBLE_MM;
  endfunction

  task automatic predict_rebound(input logic [RANGE_W-1:0] mm, input logic last);
    int                        ang;
    longint                    mag;
    longint                    quo;
    logic signed [STEER_W-1:0] prev;
    result_t                   res;
    if (scan_idx < SCAN_SAMPLES) begin
      ang = int'(start_q13) + int'(step_q13) * scan_idx;
      if (ang > 32767) ang = 32767;
      if (ang < -32768) ang = -32768;
      if ((ang >= int'(HALF_PI_Q13) || ang <= -int'(HALF_PI_Q13)) &&
          hits_bubble(scan_idx, mm)) begin
        saw_obstacle = 1'b1;
        moment_sum += longint'(ang) * longint'(mm);
        mm_sum += int'(mm);
      end
      scan_idx++;
    end
    if (last) begin
      res.ovf = 1'b0;
      if (saw_obstacle) begin
        quo = 0;
        if (mm_sum != 0) begin
          mag = (moment_sum < 0) ? -moment_sum : moment_sum;
          quo = (mag + mm_sum / 2) / mm_sum;
          if (quo > 32768) quo = 32768;
          if (moment_sum >= 0 && quo > 32767) quo = 32767;
          if (moment_sum < 0) quo = -quo;
        end
        res.steer = STEER_W'(quo);
        res.src = SRC_NEW;
        if (steer_stack.size() >= HISTORY_DEPTH) begin
          res.ovf = 1'b1;
          n_dropped++;
        end else begin
          steer_stack.push_back(res.steer);
        end
        n_rebound++;
      end else if (steer_stack.size() == 0) begin
        res.steer = '0;
        res.src = SRC_EMPTY;
        n_empty++;
      end else begin
        prev = steer_stack.pop_back();
        res.steer = (prev == STEER_MIN) ? STEER_MAX : -prev;
        res.src = SRC_RECALL;
        n_recall++;
      end
      rebound_due.push_back(res);
      scan_idx = 0;
      moment_sum = 0;
      mm_sum = 0;
      saw_obstacle = 1'b0;
    end
  endtask

  // sample driver
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
      send_gap = 0;
    end else if (!push || in_fire) begin
      if (send_gap != 0) begin
        push <= 1'b0;
        send_gap--;
      end else if (scan_samples.size() != 0) begin
        next_sample = scan_samples.pop_front();
        range_mm <= next_sample.mm;
        last_sample <= next_sample.last;
        push <= 1'b1;
        send_gap = draw_wait(send_calm);
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    in_fire <= !rst && push && !full;
    if (!rst && push && !full) begin
      n_samples++;
      predict_rebound(range_mm, last_sample);
    end
  end

  // result monitor
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      pop_hold = 0;
    end else begin
      if (out_fire) pop_hold = draw_wait(recv_calm);
      if (pop_hold != 0) begin
        pop <= 1'b0;
        pop_hold--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    out_fire <= !rst && pop && !empty;
    if (!rst && pop && !empty) begin
      n_checked++;
      if (rebound_due.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("unexpected steering item: steer %0d source %0d overflow %0d",
                   steer_angle, source, history_overflow);
      end else begin
        want = rebound_due.pop_front();
        if (steer_angle !== want.steer || source !== want.src ||
            history_overflow !== want.ovf) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("mismatch (exp/got): steer %0d/%0d source %0d/%0d overflow %0d/%0d",
                     want.steer, steer_angle, want.src, source, want.ovf,
                     history_overflow);
        end
      end
    end
  end

  task automatic queue_sample(input logic [RANGE_W-1:0] mm, input logic last);
    lidar_sample_t s;
    s.mm = mm;
    s.last = last;
    scan_samples.push_back(s);
  endtask

  task automatic queue_scan(input int len, input int flavor);
    logic [RANGE_W-1:0] mm;
    for (int n = 0; n < len; n++) begin
      case (flavor)
        NEAR: mm = RANGE_W'($urandom_range(0, 520));
        FAR:  mm = RANGE_W'($urandom_range(500, 65535));
        default: begin
          case ($urandom_range(0, 3))
            0: mm = RANGE_W'($urandom_range(0, 520));
            1: mm = '1;
            2: mm = RANGE_W'($urandom_range(0, 65535));
            default: mm = '0;
          endcase
        end
      endcase
      queue_sample(mm, n == len - 1);
    end
  endtask

  task automatic random_scans(input int budget);
    int len;
    int pick;
    int flavor;
    int used;
    used = 0;
    while (used < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 86) len = $urandom_range(1, 20);
      else if (pick < 98) len = $urandom_range(21, SCAN_SAMPLES);
      else len = $urandom_range(SCAN_SAMPLES + 1, SCAN_SAMPLES + 12);
      pick = $urandom_range(0, 99);
      flavor = (pick < 45) ? NEAR : (pick < 80) ? FAR : MIXED;
      queue_scan(len, flavor);
      used += len;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_START_ANGLE: start_q13 = val;
      REG_ANGLE_STEP:  step_q13 = val[STEP_W-1:0];
      default: ;
    endcase
    n_cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    int guard;
    guard = 0;
    while (scan_samples.size() != 0 || push) @(posedge clk);
    while (rebound_due.size() != 0 && guard < 40000) begin
      @(posedge clk);
      guard++;
    end
    repeat (80) @(posedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // zero range obstacle, then recall of the zero, then empty history
    queue_sample(16'd0, 1'b1);
    queue_sample(16'hFFFF, 1'b1);
    queue_sample(16'hFFFF, 1'b1);
    // bubble edge at the first index
    queue_sample(16'd499, 1'b1);
    queue_sample(16'd500, 1'b1);
    queue_sample(16'd100, 1'b0);
    queue_sample(16'd300, 1'b0);
    queue_sample(16'hFFFF, 1'b1);
    queue_sample(16'hFFFF, 1'b1);
    queue_sample(16'd0, 1'b0);
    queue_sample(16'd0, 1'b1);
    queue_sample(16'hFFFF, 1'b1);
    queue_sample(16'd1, 1'b0);
    queue_sample(16'hFFFF, 1'b1);
    queue_sample(16'hFFFF, 1'b1);
    queue_sample(16'hFFFE, 1'b1);
    queue_sample(16'h5555, 1'b0);
    queue_sample(16'hAAAA, 1'b1);
    settle();

    // fill the history past its depth, then drain it
    write_reg(REG_START_ANGLE, START_ANGLE_RESET);
    write_reg(REG_ANGLE_STEP, CFG_DATA_W'(ANGLE_STEP_RESET));
    repeat (HISTORY_DEPTH + 6) queue_sample(RANGE_W'($urandom_range(0, 499)), 1'b1);
    repeat (HISTORY_DEPTH + 14) queue_sample(RANGE_W'($urandom_range(500, 65535)), 1'b1);
    settle();

    write_reg(REG_START_ANGLE, 16'sd25736);
    write_reg(REG_ANGLE_STEP, 16'd2048);
    random_scans(120);
    settle();

    write_reg(REG_START_ANGLE, 16'sd0);
    write_reg(REG_ANGLE_STEP, 16'd0);
    random_scans(120);
    settle();

    write_reg(REG_START_ANGLE, -16'sd25736);
    random_scans(120);
    settle();

    write_reg(REG_START_ANGLE, CFG_DATA_W'($urandom_range(0, 51472) - 25736));
    write_reg(REG_ANGLE_STEP, CFG_DATA_W'($urandom_range(0, 2048)));
    random_scans(120);
    settle();

    // overlong scan reaches both ends of the bubble
    write_reg(REG_START_ANGLE, START_ANGLE_RESET);
    write_reg(REG_ANGLE_STEP, CFG_DATA_W'(ANGLE_STEP_RESET));
    queue_scan(SCAN_SAMPLES + 12, NEAR);
    random_scans(120);
    settle();

    if (rebound_due.size() != 0) begin
      fail_cnt += rebound_due.size();
      $display("%0d steering items never arrived", rebound_due.size());
    end
    $display("%0d lidar samples accepted over %0d register writes, %0d steering items checked",
             n_samples, n_cfg_writes, n_checked);
    $display("new rebound %0d, recalled %0d, empty history %0d, dropped pushes %0d",
             n_rebound, n_recall, n_empty, n_dropped);
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout");
    $display("Verification failed");
    $finish;
  end

endmodule
